[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define BRT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define BRT_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

[design/brt_pkg.sv]
// ----------------------------------------------------------------------------
// brt_pkg
// Shared constants, codes, command and status types of the record tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package brt_pkg;

  localparam int MAX_COLUMNS   = 64;
  localparam int NAMED_COLUMNS = 12;
  localparam int HOLD_DEPTH    = 7;

  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CFG_W  = 7;
  localparam int CNT_W  = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int HLEN_W = $clog2(HOLD_DEPTH + 1);
  localparam int HIDX_W = $clog2(HOLD_DEPTH);
  localparam int KIND_W = 3;
  localparam int OCOL_W = 6;
  localparam int BYTE_W = 8;
  localparam int VAL_W  = 64;
  localparam int ERR_W  = 3;
  localparam int REC_W  = 48;
  localparam int ODATA_W = 136;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STR_BYTE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INT_FIELD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STR_END    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ROW_END    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STREAM_END = 3'd5;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_COUNT    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_COORD    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_SHORT    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Integer columns: start, end, score, thickStart, thickEnd, blockCount.
  localparam logic [11:0] INT_COL_MAP = 12'h2D6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY,
    OP_FLUSH,
    OP_FEED,
    OP_FEED_HELD,
    OP_START,
    OP_CLOSE,
    OP_FINISH,
    OP_STREAM_END
  } op_e;

  typedef struct packed {
    op_e  op;
    logic more;      // further results of this word follow unless this step fails
    logic first;     // keyword step on the first byte of a line
    logic clr_held;  // drop the held token
    logic latch;     // capture the incoming byte
  } cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic is_blank;
    logic is_hash;
    logic kw_exact;
    logic kw_match;
    logic flush_done;
    logic out_free;
    logic emit;
    logic fail;
  } sts_t;

  function automatic logic is_int_col(input logic [COL_W-1:0] col);
    logic [3:0] sel;
    sel = 4'(col);
    return (int'(col) < NAMED_COLUMNS) && (int'(col) < 12) && INT_COL_MAP[sel];
  endfunction

  function automatic logic [7:0] track_char(input logic [HLEN_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h63;
      3'd4:    c = 8'h6B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] browser_char(input logic [HLEN_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h77;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[design/brt_datapath.sv]
// ----------------------------------------------------------------------------
// brt_datapath
// Column counter, held keyword token, integer parser and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brt_datapath import brt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic [BYTE_W-1:0]   in_byte_i,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [KIND_W-1:0]        out_kind_o,
  output logic [OCOL_W-1:0]        out_column_o,
  output logic [BYTE_W-1:0]        out_byte_o,
  output logic [VAL_W-1:0]         out_value_o,
  output logic                     out_null_o,
  output logic [ERR_W-1:0]         out_err_o,
  output logic [REC_W-1:0]         out_rec_o,
  output logic                     out_last_o
);

  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [BYTE_W-1:0] held_q [HOLD_DEPTH];
  logic [HLEN_W-1:0] hlen_q, hlen_d, idx_q, idx_d;
  logic [1:0]        cand_q, cand_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [3:0]        flags_q, flags_d;
  logic [CNT_W-1:0]  learned_q, learned_d;
  logic [CFG_W-1:0]  ccount_q;
  logic [REC_W-1:0]  rows_q, rows_d;

  logic              hw_en;
  logic [HIDX_W-1:0] hw_idx;
  logic [BYTE_W-1:0] hbyte;

  // Feed unit.
  logic [VAL_W-1:0] f_acc, f_nacc;
  logic [3:0]       f_flags, f_nflags;
  logic             f_int, f_digit;
  logic [VAL_W+3:0] f_sum;

  // Keyword match.
  logic [HLEN_W-1:0] k_pos;
  logic [1:0]        k_cand, k_c;

  // Result.
  logic              emit, fail;
  logic [KIND_W-1:0] r_kind;
  logic [BYTE_W-1:0] r_byte;
  logic [VAL_W-1:0]  r_value;
  logic              r_null;
  logic [ERR_W-1:0]  r_err;
  logic [CNT_W-1:0]  expc, cnt;
  logic              neg, ok;

  logic              ov_q;
  logic [KIND_W-1:0] ok_q;
  logic [OCOL_W-1:0] oc_q;
  logic [BYTE_W-1:0] ob_q;
  logic [VAL_W-1:0]  ovl_q;
  logic              on_q;
  logic [ERR_W-1:0]  oe_q;
  logic [REC_W-1:0]  or_q;
  logic              ol_q;
  logic              out_free;

  assign hbyte    = held_q[idx_q[HIDX_W-1:0]];
  assign expc     = (ccount_q != '0) ? CNT_W'(ccount_q) : learned_q;
  assign cnt      = CNT_W'(col_q);
  assign out_free = !ov_q || out_ready_i;

  assign k_pos  = cmd_i.first ? '0 : hlen_q;
  assign k_cand = cmd_i.first ? 2'b11 : cand_q;
  always_comb begin
    k_c = 2'b00;
    if (int'(k_pos) < 5 && track_char(k_pos) == byte_q) k_c[0] = 1'b1;
    if (int'(k_pos) < 7 && browser_char(k_pos) == byte_q) k_c[1] = 1'b1;
    k_c = k_c & k_cand;
  end

  // One byte into the integer parser; string columns just pass it on.
  assign f_acc   = (cmd_i.op == OP_START) ? '0 : acc_q;
  assign f_flags = (cmd_i.op == OP_START) ? '0 : flags_q;
  assign f_int   = is_int_col(col_q);
  assign f_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign f_sum   = {1'b0, f_acc, 3'b000} + {3'b000, f_acc, 1'b0}
                 + (VAL_W+4)'(byte_q - CH_ZERO);
  always_comb begin
    f_nacc   = f_acc;
    f_nflags = f_flags;
    if (f_int && !f_flags[3]) begin
      if (f_digit) begin
        if (f_sum > {4'b0000, 1'b1, {(VAL_W-1){1'b0}}}) f_nflags[3] = 1'b1;
        else f_nacc = f_sum[VAL_W-1:0];
        f_nflags = f_nflags | 4'b0101;
      end else if (!f_flags[0]) begin
        if (byte_q == CH_PLUS) f_nflags[0] = 1'b1;
        else if (byte_q == CH_MINUS) f_nflags[1:0] = 2'b11;
        else if (byte_q != CH_VT && byte_q != CH_FF) f_nflags[3] = 1'b1;
      end else begin
        f_nflags[3] = 1'b1;
      end
    end
  end

  assign neg = flags_q[1];
  assign ok  = flags_q[2] && !flags_q[3] && (neg || !acc_q[VAL_W-1]);

  always_comb begin
    byte_d    = cmd_i.latch ? in_byte_i : byte_q;
    col_d     = col_q;
    hlen_d    = hlen_q;
    idx_d     = idx_q;
    cand_d    = cand_q;
    acc_d     = acc_q;
    flags_d   = flags_q;
    learned_d = learned_q;
    rows_d    = rows_q;
    hw_en     = 1'b0;
    hw_idx    = k_pos[HIDX_W-1:0];
    emit      = 1'b0;
    fail      = 1'b0;
    r_kind    = KIND_STR_BYTE;
    r_byte    = '0;
    r_value   = '0;
    r_null    = 1'b0;
    r_err     = ERR_NONE;
    unique case (cmd_i.op)
      OP_KEY: begin
        if (k_c != 2'b00 && int'(k_pos) < HOLD_DEPTH) begin
          hw_en  = 1'b1;
          hlen_d = k_pos + 1'b1;
          cand_d = k_c;
        end else begin
          col_d   = '0;
          acc_d   = '0;
          flags_d = '0;
          idx_d   = '0;
          hlen_d  = k_pos;
        end
      end
      OP_FLUSH: begin
        col_d   = '0;
        acc_d   = '0;
        flags_d = '0;
        idx_d   = '0;
      end
      OP_FEED: begin
        acc_d   = f_nacc;
        flags_d = f_nflags;
        emit    = !f_int;
        r_byte  = byte_q;
      end
      OP_FEED_HELD: begin
        emit   = 1'b1;
        r_byte = hbyte;
        idx_d  = idx_q + 1'b1;
      end
      OP_START: begin
        if (col_q >= COL_W'(MAX_COLUMNS)) begin
          fail  = 1'b1;
          r_err = ERR_TOO_MANY;
        end else if (expc != '0 && cnt >= expc) begin
          fail  = 1'b1;
          r_err = ERR_COUNT;
        end else begin
          acc_d   = f_nacc;
          flags_d = f_nflags;
          emit    = !f_int;
          r_byte  = byte_q;
        end
      end
      OP_CLOSE: begin
        if (f_int) begin
          if (!ok && (cnt == CNT_W'(1) || cnt == CNT_W'(2))) begin
            fail  = 1'b1;
            r_err = ERR_COORD;
          end else begin
            emit    = 1'b1;
            r_kind  = KIND_INT_FIELD;
            r_value = ok ? (neg ? (VAL_W'(0) - acc_q) : acc_q) : '0;
            r_null  = !ok;
            col_d   = col_q + 1'b1;
          end
        end else begin
          emit   = 1'b1;
          r_kind = KIND_STR_END;
          col_d  = col_q + 1'b1;
        end
      end
      OP_FINISH: begin
        col_d = '0;
        if (expc == '0) begin
          if (cnt < CNT_W'(3)) begin
            fail  = 1'b1;
            r_err = ERR_SHORT;
          end else begin
            learned_d = cnt;
          end
        end else if (cnt != expc) begin
          fail  = 1'b1;
          r_err = ERR_COUNT;
        end else if (cnt < CNT_W'(3)) begin
          fail  = 1'b1;
          r_err = ERR_SHORT;
        end
        if (!fail) begin
          emit   = 1'b1;
          r_kind = KIND_ROW_END;
          if (rows_q != {REC_W{1'b1}}) rows_d = rows_q + 1'b1;
        end
      end
      OP_STREAM_END: begin
        emit   = 1'b1;
        r_kind = KIND_STREAM_END;
      end
      default: begin
      end
    endcase
    if (fail) begin
      emit   = 1'b1;
      r_kind = KIND_ERROR;
    end
    if (cmd_i.clr_held) hlen_d = '0;
  end

  always_comb begin
    sts_o.is_cr      = (byte_q == CH_CR);
    sts_o.is_lf      = (byte_q == CH_LF);
    sts_o.is_blank   = (byte_q == CH_SP) || (byte_q == CH_TAB);
    sts_o.is_hash    = (byte_q == CH_HASH);
    sts_o.kw_exact   = (cand_q[0] && int'(hlen_q) == 5) || (cand_q[1] && int'(hlen_q) == 7);
    sts_o.kw_match   = (k_c != 2'b00) && (int'(k_pos) < HOLD_DEPTH);
    sts_o.flush_done = (idx_q == hlen_q);
    sts_o.out_free   = out_free;
    sts_o.emit       = emit;
    sts_o.fail       = fail;
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) held_q[hw_idx] <= byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      hlen_q    <= '0;
      idx_q     <= '0;
      cand_q    <= 2'b11;
      acc_q     <= '0;
      flags_q   <= '0;
      learned_q <= '0;
      ccount_q  <= '0;
      rows_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      col_q     <= col_d;
      hlen_q    <= hlen_d;
      idx_q     <= idx_d;
      cand_q    <= cand_d;
      acc_q     <= acc_d;
      flags_q   <= flags_d;
      learned_q <= learned_d;
      rows_q    <= rows_d;
      if (cfg_valid_i) ccount_q <= cfg_data_i;
      ov_q      <= emit || (ov_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (emit) begin
      ok_q  <= r_kind;
      oc_q  <= (r_kind == KIND_ERROR || r_kind == KIND_ROW_END ||
                r_kind == KIND_STREAM_END) ? '0 : OCOL_W'(col_q);
      ob_q  <= r_byte;
      ovl_q <= r_value;
      on_q  <= r_null;
      oe_q  <= r_err;
      or_q  <= rows_d;
      ol_q  <= !cmd_i.more || fail;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = ok_q;
  assign out_column_o = oc_q;
  assign out_byte_o   = ob_q;
  assign out_value_o  = ovl_q;
  assign out_null_o   = on_q;
  assign out_err_o    = oe_q;
  assign out_rec_o    = or_q;
  assign out_last_o   = ol_q;

endmodule

`default_nettype wire

[design/brt_ctrl.sv]
// ----------------------------------------------------------------------------
// brt_ctrl
// Line phase tracking and sequencing of the datapath steps of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module brt_ctrl import brt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_eoi_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_FLUSH, ST_CLOSE, ST_FINISH, ST_END
  } state_e;

  typedef enum logic [2:0] {
    PH_START, PH_KEYWORD, PH_SKIP, PH_FIELD, PH_GAP
  } phase_e;

  typedef enum logic [1:0] {
    ACT_FEED, ACT_CLOSE, ACT_CLOSE_FINISH
  } act_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  act_e   act_q, act_d;
  logic   eoi_q, eoi_d, eol_q, eol_d, halted_q, halted_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    act_d      = act_q;
    eoi_d      = eoi_q;
    eol_d      = eol_q;
    halted_d   = halted_q;
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !halted_q) begin
          cmd_o.latch = 1'b1;
          eoi_d       = in_eoi_i;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
          if (eoi_q || sts_i.is_lf) begin
            eol_d = 1'b1;
            unique case (phase_q)
              PH_KEYWORD: begin
                if (sts_i.kw_exact) begin
                  cmd_o.clr_held = 1'b1;
                  phase_d        = PH_START;
                  state_d        = eoi_q ? ST_END : ST_IDLE;
                end else begin
                  cmd_o.op = OP_FLUSH;
                  act_d    = ACT_CLOSE_FINISH;
                  phase_d  = PH_FIELD;
                  state_d  = ST_FLUSH;
                end
              end
              PH_FIELD: state_d = ST_CLOSE;
              PH_GAP:   state_d = ST_FINISH;
              default: begin
                phase_d = PH_START;
                state_d = eoi_q ? ST_END : ST_IDLE;
              end
            endcase
          end else if (sts_i.is_cr) begin
            state_d = ST_IDLE;
          end else if (sts_i.is_blank) begin
            eol_d = 1'b0;
            if (phase_q == PH_KEYWORD) begin
              if (sts_i.kw_exact) begin
                cmd_o.clr_held = 1'b1;
                phase_d        = PH_SKIP;
              end else begin
                cmd_o.op = OP_FLUSH;
                act_d    = ACT_CLOSE;
                phase_d  = PH_FIELD;
                state_d  = ST_FLUSH;
              end
            end else if (phase_q == PH_FIELD) begin
              state_d = ST_CLOSE;
            end
          end else begin
            unique case (phase_q)
              PH_START, PH_KEYWORD: begin
                if (phase_q == PH_START && sts_i.is_hash) begin
                  phase_d = PH_SKIP;
                end else begin
                  cmd_o.op    = OP_KEY;
                  cmd_o.first = (phase_q == PH_START);
                  phase_d     = PH_KEYWORD;
                  if (!sts_i.kw_match) begin
                    phase_d = PH_FIELD;
                    act_d   = ACT_FEED;
                    state_d = ST_FLUSH;
                  end
                end
              end
              PH_FIELD: cmd_o.op = OP_FEED;
              PH_GAP: begin
                cmd_o.op = OP_START;
                if (sts_i.fail) halted_d = 1'b1;
                else phase_d = PH_FIELD;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          if (!sts_i.flush_done) begin
            cmd_o.op   = OP_FEED_HELD;
            cmd_o.more = 1'b1;
          end else begin
            cmd_o.clr_held = 1'b1;
            state_d        = ST_IDLE;
            unique case (act_q)
              ACT_FEED: cmd_o.op = OP_FEED;
              ACT_CLOSE: begin
                cmd_o.op = OP_CLOSE;
                phase_d  = PH_GAP;
              end
              ACT_CLOSE_FINISH: begin
                cmd_o.op   = OP_CLOSE;
                cmd_o.more = 1'b1;
                phase_d    = PH_GAP;
                state_d    = ST_FINISH;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.op   = OP_CLOSE;
          cmd_o.more = eol_q;
          if (sts_i.fail) begin
            halted_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            phase_d = PH_GAP;
            state_d = eol_q ? ST_FINISH : ST_IDLE;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.more = eoi_q;
          phase_d    = PH_START;
          if (sts_i.fail) begin
            halted_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = eoi_q ? ST_END : ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_STREAM_END;
          halted_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_START;
      act_q    <= ACT_FEED;
      eoi_q    <= 1'b0;
      eol_q    <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      act_q    <= act_d;
      eoi_q    <= eoi_d;
      eol_q    <= eol_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

[design/bed_record_tokenizer.sv]
// A word is taken in ST_IDLE and decoded in ST_DISPATCH, which waits while
// the result register is occupied; a result is registered and shows on the
// master side in the cycle after its step runs. A new word is taken only
// once all steps of the last are done; results leave at one per cycle
// through the single result register while the master side takes them.
// Reset: asynchronous, active low; returns to line start with no rows counted.
// ----------------------------------------------------------------------------
// bed_record_tokenizer
// Byte-serial tokenizer for BED text: splits data lines into fields, parses
// the integer columns and reports rows, errors and the end of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bed_record_tokenizer import brt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration: expected column count, 0 learns it from the first row.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  // Input words.
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [7:0]         s_axis_tdata_i,   // [7:0] text_byte
  input  wire logic               s_axis_tlast_i,   // end_of_input
  // Result words.
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [5:0] column, [13:6] field_byte, [77:14] int_value, [78] is_null,
  // [81:79] error_code, [129:82] record_count, [135:130] zero
  output logic [ODATA_W-1:0]      m_axis_tdata_o,
  output logic [KIND_W-1:0]       m_axis_tuser_o,   // [2:0] kind
  output logic                    m_axis_tlast_o    // last
);

  cmd_t cmd;
  sts_t sts;

  logic [OCOL_W-1:0] o_col;
  logic [BYTE_W-1:0] o_byte;
  logic [VAL_W-1:0]  o_val;
  logic              o_null;
  logic [ERR_W-1:0]  o_err;
  logic [REC_W-1:0]  o_rec;

  // The register can be written whenever the host offers it; the host must do
  // so only while the tokenizer is idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // The controller owns the line phase and decides which datapath step runs
  // in each cycle; a step waits while the result register is full and unread.
  brt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_eoi_i   (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the column count, the held first token, the integer
  // accumulator and the result register.
  brt_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_byte_i    (s_axis_tdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_kind_o   (m_axis_tuser_o),
    .out_column_o (o_col),
    .out_byte_o   (o_byte),
    .out_value_o  (o_val),
    .out_null_o   (o_null),
    .out_err_o    (o_err),
    .out_rec_o    (o_rec),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b000000, o_rec, o_err, o_null, o_val, o_byte, o_col};

  // A new result is only produced when the result register can take it.
  `BRT_ASSERT(a_emit_has_room, clk_i, rst_ni, !sts.emit || sts.out_free)
  // Errors and the stream end always close the results of their word.
  `BRT_ASSERT(a_final_marked, clk_i, rst_ni,
    !(m_axis_tvalid_o && (m_axis_tuser_o == KIND_ERROR ||
      m_axis_tuser_o == KIND_STREAM_END)) || m_axis_tlast_o)
  // A failing step must be one that reports the failure.
  `BRT_ASSERT_NEVER(a_fail_silent, clk_i, rst_ni, sts.fail && !sts.emit)

endmodule

`default_nettype wire
